// ===== hdl/aesg_pkg.sv =====
package aesg_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_GEN  = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  // lane keys, byte 0 in bits [7:0]
  localparam logic [127:0] LANE_KEY [4] = '{
    128'hb4f44917dbb5552b627166096daca553,
    128'h0da1dc4e1725d378846a710d6d7caf07,
    128'h3e20e345f4c0794f9f947ec63f1262f1,
    128'h4916915416314c88b1ba317c6aef8135
  };

  typedef logic [7:0] byte_t;

  function automatic byte_t xt(input byte_t a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gmul(input byte_t a, input byte_t b);
    byte_t p;
    byte_t x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  function automatic byte_t ginv(input byte_t a);
    byte_t r;
    byte_t sq;
    // a^254 by square and multiply
    r = 8'h01;
    sq = a;
    for (int i = 1; i < 8; i++) begin
      sq = gmul(sq, sq);
      r = gmul(r, sq);
    end
    ginv = r;
  endfunction

  function automatic byte_t rotl(input byte_t v, input int n);
    rotl = byte_t'((v << n) | (v >> (8 - n)));
  endfunction

  function automatic byte_t sbox_calc(input byte_t x);
    byte_t b;
    b = ginv(x);
    sbox_calc = b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
  endfunction

  function automatic byte_t inv_sbox_calc(input byte_t s);
    byte_t y;
    y = rotl(s, 1) ^ rotl(s, 3) ^ rotl(s, 6) ^ 8'h05;
    inv_sbox_calc = ginv(y);
  endfunction

  // both s-boxes folded into constant tables at elaboration
  function automatic logic [2047:0] fwd_table();
    logic [2047:0] tab;
    for (int i = 0; i < 256; i++) begin
      tab[8*i +: 8] = sbox_calc(byte_t'(i));
    end
    return tab;
  endfunction

  function automatic logic [2047:0] inv_table();
    logic [2047:0] tab;
    for (int i = 0; i < 256; i++) begin
      tab[8*i +: 8] = inv_sbox_calc(byte_t'(i));
    end
    return tab;
  endfunction

  localparam logic [2047:0] FWD_TAB = fwd_table();
  localparam logic [2047:0] INV_TAB = inv_table();

  function automatic byte_t sbox(input byte_t x);
    sbox = FWD_TAB[8*x +: 8];
  endfunction

  function automatic byte_t inv_sbox(input byte_t s);
    inv_sbox = INV_TAB[8*s +: 8];
  endfunction

endpackage

// ===== hdl/aesg_lane.sv =====
// one aes round on a 128-bit lane, enc or dec form
module aesg_lane #(
  parameter bit DEC = 1'b0
) (
  input  logic [127:0] lane_in,
  input  logic [127:0] key,
  output logic [127:0] lane_out
);

  aesg_pkg::byte_t s [16];
  aesg_pkg::byte_t t [16];

  // shift rows and substitute
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (DEC) begin
          t[r + 4*c] = aesg_pkg::inv_sbox(lane_in[8*(r + 4*((c - r + 4) % 4)) +: 8]);
        end else begin
          t[r + 4*c] = aesg_pkg::sbox(lane_in[8*(r + 4*((c + r) % 4)) +: 8]);
        end
      end
    end
  end

  // mix columns and key add
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (DEC) begin
          s[4*c + r] = aesg_pkg::gmul(t[4*c + r], 8'd14)
                     ^ aesg_pkg::gmul(t[4*c + (r+1)%4], 8'd11)
                     ^ aesg_pkg::gmul(t[4*c + (r+2)%4], 8'd13)
                     ^ aesg_pkg::gmul(t[4*c + (r+3)%4], 8'd9);
        end else begin
          s[4*c + r] = aesg_pkg::xt(t[4*c + r])
                     ^ aesg_pkg::xt(t[4*c + (r+1)%4]) ^ t[4*c + (r+1)%4]
                     ^ t[4*c + (r+2)%4] ^ t[4*c + (r+3)%4];
        end
        lane_out[8*(4*c + r) +: 8] = s[4*c + r] ^ key[8*(4*c + r) +: 8];
      end
    end
  end

endmodule

// ===== hdl/aes_one_round_generator.sv =====
// One-round AES generator over a 512-bit state of eight 64-bit words (four
// 128-bit lanes; lanes 0 and 2 take an aesdec round, 1 and 3 an aesenc round).
// A load beat writes one state word and gives no result; a generate beat
// advances the state and gives eight result beats, words 0..7, with
// last_word on word 7; a read beat gives one result with last_word set.
// The round logic sits between the state register and an output buffer, and
// generate results leave through the 64-bit result port one word per beat, as
// out_ready allows. The first result beat appears the cycle after the item is taken.
// A new item of any kind is taken only when the buffer is empty or in the
// cycle that the last result beat of the previous item leaves.
module aes_one_round_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_word_index,
  input  logic [63:0] in_seed_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_out_word,
  output logic        out_last_word
);

  logic [511:0] state_r, state_nxt;
  logic [511:0] round_val;
  logic [511:0] buf_r, buf_nxt;
  logic [2:0]   cnt_r, cnt_nxt;
  logic [2:0]   left_r, left_nxt;   // beats still to send after current
  logic         valid_r, valid_nxt;
  logic         last_ok;
  logic         acc;

  // round lanes
  aesg_lane #(.DEC(1'b1)) u_l0 (.lane_in(state_r[127:0]),   .key(aesg_pkg::LANE_KEY[0]),
                                .lane_out(round_val[127:0]));
  aesg_lane #(.DEC(1'b0)) u_l1 (.lane_in(state_r[255:128]), .key(aesg_pkg::LANE_KEY[1]),
                                .lane_out(round_val[255:128]));
  aesg_lane #(.DEC(1'b1)) u_l2 (.lane_in(state_r[383:256]), .key(aesg_pkg::LANE_KEY[2]),
                                .lane_out(round_val[383:256]));
  aesg_lane #(.DEC(1'b0)) u_l3 (.lane_in(state_r[511:384]), .key(aesg_pkg::LANE_KEY[3]),
                                .lane_out(round_val[511:384]));

  // accept when buffer is empty or draining its final beat
  assign last_ok  = out_ready && (left_r == 3'd0);
  assign in_ready = !valid_r || last_ok;
  assign acc      = in_valid && in_ready;

  assign out_valid     = valid_r;
  assign out_out_word  = buf_r[64*cnt_r +: 64];
  assign out_last_word = (left_r == 3'd0);

  // state and output buffer control
  always_comb begin
    state_nxt = state_r;
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    valid_nxt = valid_r;
    if (valid_r && out_ready) begin
      if (left_r == 3'd0) begin
        valid_nxt = 1'b0;
      end else begin
        cnt_nxt  = cnt_r + 3'd1;
        left_nxt = left_r - 3'd1;
      end
    end
    if (acc) begin
      case (aesg_pkg::action_t'(in_action))
        aesg_pkg::ACT_LOAD: begin
          state_nxt[64*in_word_index +: 64] = in_seed_word;
        end
        aesg_pkg::ACT_GEN: begin
          state_nxt = round_val;
          buf_nxt   = round_val;
          cnt_nxt   = 3'd0;
          left_nxt  = 3'd7;
          valid_nxt = 1'b1;
        end
        aesg_pkg::ACT_READ: begin
          buf_nxt   = state_r;
          cnt_nxt   = in_word_index;
          left_nxt  = 3'd0;
          valid_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      cnt_r   <= '0;
      left_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      left_r  <= left_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

// ===== hdl/aesg_checker.sv =====
// port-level checks
module aesg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_out_word,
  input logic        out_last_word
);

  // held result beat stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_out_word) && $stable(out_last_word))
    else $error("result beat changed while stalled");

  // generate gives a non-last first beat next cycle
  a_gen: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == aesg_pkg::ACT_GEN |=> out_valid && !out_last_word)
    else $error("generate did not start a block");

  // read gives a single last beat
  a_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == aesg_pkg::ACT_READ |=> out_valid && out_last_word)
    else $error("read result missing");

  // no input taken mid-block
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_word |-> !in_ready)
    else $error("input taken during a block");

endmodule

bind aes_one_round_generator aesg_checker u_aesg_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_action(in_action), .out_valid(out_valid), .out_ready(out_ready),
  .out_out_word(out_out_word), .out_last_word(out_last_word)
);
